@@ src/bmd_pkg.sv @@
// Shared types, constants and codes of the binary mask dilation block.
package bmd_pkg;

    localparam int SRC_MAX_W  = 64;
    localparam int SRC_MAX_H  = 64;
    localparam int MASK_MAX_W = 8;
    localparam int MASK_MAX_H = 8;

    localparam int SRC_DEPTH  = SRC_MAX_W * SRC_MAX_H;
    localparam int MASK_DEPTH = MASK_MAX_W * MASK_MAX_H;
    localparam int SRC_AW     = $clog2(SRC_DEPTH);
    localparam int MASK_AW    = $clog2(MASK_DEPTH);

    // Item action codes.
    localparam logic [1:0] ACT_SRC_WR  = 2'd0;
    localparam logic [1:0] ACT_MASK_WR = 2'd1;
    localparam logic [1:0] ACT_EVAL    = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SRC_W  = 3'd0;
    localparam logic [2:0] CFG_SRC_H  = 3'd1;
    localparam logic [2:0] CFG_MASK_W = 3'd2;
    localparam logic [2:0] CFG_MASK_H = 3'd3;
    localparam logic [2:0] CFG_DST_W  = 3'd4;
    localparam logic [2:0] CFG_DST_H  = 3'd5;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] col;
        logic [5:0] row;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        logic hit;
        logic in_region;
    } t_out_item;

    typedef struct packed {
        logic [6:0] src_width;
        logic [6:0] src_height;
        logic [3:0] mask_width;
        logic [3:0] mask_height;
        logic [6:0] dst_width;
        logic [6:0] dst_height;
    } t_cfg;

    typedef struct packed {
        logic               src_we;
        logic               mask_we;
        logic [SRC_AW-1:0]  src_waddr;
        logic [MASK_AW-1:0] mask_waddr;
        logic [7:0]         wdata;
        logic               rd_en;
        logic [SRC_AW-1:0]  src_raddr;
        logic [MASK_AW-1:0] mask_raddr;
    } t_store_req;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

@@ src/binary_mask_dilation.sv @@
// Evaluate items: the window scan visits its source cells one at a time, at most
// mask_width*mask_height (64 with an 8x8 mask), set by the single source memory read
// port; the result is registered via ST_DRAIN and ST_DONE, or from ST_DONE on a hit.
// Write items: the result is registered at the edge that takes the item.
// One item at a time; the next item is taken once back in idle with the output free.
// Reset restores the configuration defaults and clears control; the cell memories are
// undefined until written and get no clearing pass.
module binary_mask_dilation (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bmd_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bmd_pkg::t_out_item o_out_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [6:0]        i_cfg_data
);
    import bmd_pkg::*;

    t_cfg       r_cfg;
    logic       r_out_valid;
    t_out_item  r_out_data;
    logic       accept, out_free, busy;
    logic [7:0] src_byte, mask_byte;
    t_store_req req;
    t_result    result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = busy || !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width   <= 7'd64;
            r_cfg.src_height  <= 7'd64;
            r_cfg.mask_width  <= 4'd3;
            r_cfg.mask_height <= 4'd3;
            r_cfg.dst_width   <= 7'd64;
            r_cfg.dst_height  <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_W:  r_cfg.src_width   <= i_cfg_data;
                CFG_SRC_H:  r_cfg.src_height  <= i_cfg_data;
                CFG_MASK_W: r_cfg.mask_width  <= i_cfg_data[3:0];
                CFG_MASK_H: r_cfg.mask_height <= i_cfg_data[3:0];
                CFG_DST_W:  r_cfg.dst_width   <= i_cfg_data;
                CFG_DST_H:  r_cfg.dst_height  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_out_data <= result.item;
        end
    end

    bmd_scan_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_data),
        .i_cfg       (r_cfg),
        .i_out_free  (out_free),
        .i_src_byte  (src_byte),
        .i_mask_byte (mask_byte),
        .o_req       (req),
        .o_result    (result),
        .o_busy      (busy)
    );

    bmd_cell_store u_store (
        .i_clk       (i_clk),
        .i_req       (req),
        .o_src_byte  (src_byte),
        .o_mask_byte (mask_byte)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ src/bmd_cell_store.sv @@
// Source grid and mask memories with one write port and a registered read each.
module bmd_cell_store (
    input  logic                i_clk,
    input  bmd_pkg::t_store_req i_req,
    output logic [7:0]          o_src_byte,
    output logic [7:0]          o_mask_byte
);
    import bmd_pkg::*;

    logic [7:0] r_src_mem  [SRC_DEPTH];
    logic [7:0] r_mask_mem [MASK_DEPTH];
    logic [7:0] r_src_byte;
    logic [7:0] r_mask_byte;

    always_ff @(posedge i_clk) begin
        if (i_req.src_we) begin
            r_src_mem[i_req.src_waddr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_src_byte <= r_src_mem[i_req.src_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.mask_we) begin
            r_mask_mem[i_req.mask_waddr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_mask_byte <= r_mask_mem[i_req.mask_raddr];
        end
    end

    assign o_src_byte  = r_src_byte;
    assign o_mask_byte = r_mask_byte;

endmodule

@@ src/bmd_scan_ctrl.sv @@
// Sequencer that walks the scan window and feeds the shared AND and compare unit.
module bmd_scan_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  bmd_pkg::t_in_item   i_item,
    input  bmd_pkg::t_cfg       i_cfg,
    input  logic                i_out_free,
    input  logic [7:0]          i_src_byte,
    input  logic [7:0]          i_mask_byte,
    output bmd_pkg::t_store_req o_req,
    output bmd_pkg::t_result    o_result,
    output logic                o_busy
);
    import bmd_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_x, n_x, r_y, n_y;
    logic [5:0] r_x0, n_x0, r_x1, n_x1, r_y1, n_y1;
    logic [3:0] r_mx, n_mx, r_my, n_my, r_mx0, n_mx0;
    logic       r_pend, n_pend, r_pend_moob, n_pend_moob;
    logic       r_hit, n_hit, r_region, n_region;

    // Window bounds worked out from the item being accepted.
    logic       row_ge, col_ge;
    logic [5:0] y0, y1, x0, x1;
    logic [3:0] my0, mx0;
    logic       empty, region;
    logic       hit_now, moob, last_col, last_row;

    always_comb begin
        row_ge = {2'b00, i_item.row} >= {4'b0000, i_cfg.mask_height};
        col_ge = {2'b00, i_item.col} >= {4'b0000, i_cfg.mask_width};
        y0  = row_ge ? i_item.row - {2'b00, i_cfg.mask_height} : 6'd0;
        x0  = col_ge ? i_item.col - {2'b00, i_cfg.mask_width}  : 6'd0;
        my0 = row_ge ? 4'd0 : i_cfg.mask_height - i_item.row[3:0];
        mx0 = col_ge ? 4'd0 : i_cfg.mask_width  - i_item.col[3:0];
        y1  = (i_cfg.src_height < {1'b0, i_item.row}) ? i_cfg.src_height[5:0] : i_item.row;
        x1  = (i_cfg.src_width  < {1'b0, i_item.col}) ? i_cfg.src_width[5:0]  : i_item.col;
        empty  = (y0 >= y1) || (x0 >= x1);
        region = ({2'b00, i_item.col} + {4'b0000, i_cfg.mask_width}
                  < {1'b0, i_cfg.dst_width})
              && ({2'b00, i_item.row} + {4'b0000, i_cfg.mask_height}
                  < {1'b0, i_cfg.dst_height});
    end

    // Shared unit: one AND and zero test per cycle on the bytes read last cycle.
    assign hit_now  = r_pend && !r_pend_moob && ((i_src_byte & i_mask_byte) != 8'd0);
    assign moob     = (int'(r_mx) >= MASK_MAX_W) || (int'(r_my) >= MASK_MAX_H);
    assign last_col = (r_x + 6'd1) == r_x1;
    assign last_row = (r_y + 6'd1) == r_y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_y         <= n_y;
        r_x0        <= n_x0;
        r_x1        <= n_x1;
        r_y1        <= n_y1;
        r_mx        <= n_mx;
        r_my        <= n_my;
        r_mx0       <= n_mx0;
        r_pend_moob <= n_pend_moob;
        r_hit       <= n_hit;
        r_region    <= n_region;
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_x0        = r_x0;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_mx        = r_mx;
        n_my        = r_my;
        n_mx0       = r_mx0;
        n_pend      = 1'b0;
        n_pend_moob = r_pend_moob;
        n_hit       = r_hit;
        n_region    = r_region;
        o_req       = '0;
        o_req.wdata      = i_item.value;
        o_req.src_waddr  = SRC_AW'(int'(i_item.row) * SRC_MAX_W + int'(i_item.col));
        o_req.mask_waddr = MASK_AW'(int'(i_item.row) * MASK_MAX_W + int'(i_item.col));
        o_req.src_raddr  = SRC_AW'(int'(r_y) * SRC_MAX_W + int'(r_x));
        o_req.mask_raddr = MASK_AW'(int'(r_my) * MASK_MAX_W + int'(r_mx));
        o_result    = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    case (i_item.action)
                        ACT_SRC_WR: begin
                            o_req.src_we = (int'(i_item.col) < SRC_MAX_W)
                                        && (int'(i_item.row) < SRC_MAX_H);
                            o_result.valid = 1'b1;
                        end
                        ACT_MASK_WR: begin
                            o_req.mask_we = (int'(i_item.col) < MASK_MAX_W)
                                         && (int'(i_item.row) < MASK_MAX_H);
                            o_result.valid = 1'b1;
                        end
                        ACT_EVAL: begin
                            n_x      = x0;
                            n_x0     = x0;
                            n_x1     = x1;
                            n_y      = y0;
                            n_y1     = y1;
                            n_mx     = mx0;
                            n_mx0    = mx0;
                            n_my     = my0;
                            n_hit    = 1'b0;
                            n_region = region;
                            n_state  = empty ? ST_DONE : ST_SCAN;
                        end
                        default: begin
                            o_result.valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit_now) begin
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    o_req.rd_en = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_moob = moob;
                    if (last_col) begin
                        n_x  = r_x0;
                        n_mx = r_mx0;
                        n_y  = r_y + 6'd1;
                        n_my = r_my + 4'd1;
                        if (last_row) begin
                            n_state = ST_DRAIN;
                        end
                    end else begin
                        n_x  = r_x + 6'd1;
                        n_mx = r_mx + 4'd1;
                    end
                end
            end
            ST_DRAIN: begin
                n_hit   = hit_now;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_result.valid          = 1'b1;
                    o_result.item.hit       = r_hit;
                    o_result.item.in_region = r_region;
                    n_state                 = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
